// ===== rtl/mss_pkg.sv =====
package mss_pkg;

    // Field widths fixed by the store format
    localparam int ADDR_W   = 64;
    localparam int DATA_W   = 64;
    localparam int INDEX_W  = 10;
    localparam int SIZE_W   = 4;
    localparam int OFF_W    = 3;
    localparam int KIND_W   = 2;
    localparam int CFG_IDX_W = 3;
    localparam int COUNT_W  = 2;

    // Largest number of MMIO ranges the config port can address
    localparam int MAX_MMIO_RANGES = 3;
    localparam int DEF_MMIO_RANGES = 3;

    // Queue between classifier and issue side
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    localparam logic [SIZE_W-1:0] WORD_BYTES = SIZE_W'(8);

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_COUNT  = 3'd0,
        REG_RANGE0_START = 3'd1,
        REG_RANGE0_END   = 3'd2,
        REG_RANGE1_START = 3'd3,
        REG_RANGE1_END   = 3'd4,
        REG_RANGE2_START = 3'd5,
        REG_RANGE2_END   = 3'd6
    } cfg_reg_t;

    // Result word kinds as seen on the port
    typedef enum logic [KIND_W-1:0] {
        PART_DIRECT = 2'd0,
        PART_BLOCK  = 2'd1,
        PART_ERROR  = 2'd2
    } part_kind_t;

    // Classification made by the front end
    typedef enum logic [1:0] {
        CLS_DIRECT,
        CLS_SPLIT,
        CLS_ERROR
    } store_class_t;

    // Issue side sequencing
    typedef enum logic {
        BACK_FIRST,
        BACK_SECOND
    } back_state_t;

    // One classified store waiting in the queue
    typedef struct packed {
        store_class_t        cls;
        logic [ADDR_W-1:0]   addr;
        logic [SIZE_W-1:0]   size;
        logic [DATA_W-1:0]   data;
    } entry_t;

    // One result word
    typedef struct packed {
        part_kind_t          kind;
        logic [ADDR_W-1:0]   addr;
        logic [OFF_W-1:0]    offset;
        logic [SIZE_W-1:0]   bytes;
        logic [DATA_W-1:0]   data;
        logic                last;
    } result_t;

    // Mask of the low n bytes, n from 0 to 8 (8 and above give all ones)
    function automatic logic [DATA_W-1:0] byte_mask(input logic [SIZE_W-1:0] n);
        logic [DATA_W-1:0] m;
        if (n >= WORD_BYTES) begin
            m = '1;
        end else begin
            m = (DATA_W'(1) << {n[OFF_W-1:0], 3'b000}) - DATA_W'(1);
        end
        return m;
    endfunction

endpackage

// ===== rtl/mss_front.sv =====
module mss_front
    import mss_pkg::*;
#(
    parameter int NUM_MMIO_RANGES = DEF_MMIO_RANGES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 accept,
    input  logic                 kind,
    input  logic [ADDR_W-1:0]    address,
    input  logic [INDEX_W-1:0]   element_index,
    input  logic [SIZE_W-1:0]    byte_count,
    input  logic [DATA_W-1:0]    store_data,
    input  logic                 active,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output logic                 load,
    output logic                 push,
    output entry_t               push_entry
);

    localparam int PROD_W = INDEX_W + SIZE_W;

    logic [COUNT_W-1:0] range_count_reg;
    logic [ADDR_W-1:0]  range_start_reg [NUM_MMIO_RANGES];
    logic [ADDR_W-1:0]  range_end_reg   [NUM_MMIO_RANGES];

    logic               s1_valid_reg;
    logic [ADDR_W-1:0]  s1_addr_reg;
    logic [SIZE_W-1:0]  s1_size_reg;
    logic [DATA_W-1:0]  s1_data_reg;

    logic [SIZE_W-1:0]  size_clamp;
    logic [PROD_W-1:0]  stride_offset;
    logic [ADDR_W-1:0]  addr_next;
    logic               has_result;

    logic [OFF_W-1:0]   offset;
    logic               crosses;
    logic [ADDR_W-1:0]  block0;
    logic [ADDR_W-1:0]  block1;

    // Address lies in one of the enabled ranges
    function automatic logic in_mmio(input logic [ADDR_W-1:0] a);
        logic hit;
        hit = 1'b0;
        for (int r = 0; r < NUM_MMIO_RANGES; r++) begin
            if ((COUNT_W'(r) < range_count_reg) && (a >= range_start_reg[r])
                && (a < range_end_reg[r])) begin
                hit = 1'b1;
            end
        end
        return hit;
    endfunction

    // Hold range registers; they are to be written only while idle, which the block does not enforce
    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            range_count_reg <= '0;
            for (int r = 0; r < NUM_MMIO_RANGES; r++) begin
                range_start_reg[r] <= '0;
                range_end_reg[r]   <= '0;
            end
        end else if (cfg_write) begin
            if (cfg_index == REG_RANGE_COUNT) begin
                range_count_reg <= cfg_data[COUNT_W-1:0];
            end
            for (int r = 0; r < NUM_MMIO_RANGES; r++) begin
                if (cfg_index == CFG_IDX_W'(REG_RANGE0_START) + CFG_IDX_W'(2 * r)) begin
                    range_start_reg[r] <= cfg_data;
                end
                if (cfg_index == CFG_IDX_W'(REG_RANGE0_END) + CFG_IDX_W'(2 * r)) begin
                    range_end_reg[r] <= cfg_data;
                end
            end
        end
    end

    // Stage 1: effective address, clamped size, trimmed data
    assign size_clamp    = (byte_count > WORD_BYTES) ? WORD_BYTES : byte_count;
    assign stride_offset = element_index * PROD_W'(size_clamp);
    assign addr_next     = kind ? (address + ADDR_W'(stride_offset)) : address;
    assign has_result    = !(kind && !active) && (byte_count != '0);
    assign load          = accept && has_result;

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            s1_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= load;
        end
    end

    always_ff @(posedge clk) begin
        if (load) begin
            s1_addr_reg <= addr_next;
            s1_size_reg <= size_clamp;
            s1_data_reg <= store_data & byte_mask(size_clamp);
        end
    end

    // Stage 2: word crossing and MMIO checks, then queue the store
    assign offset  = s1_addr_reg[OFF_W-1:0];
    assign crosses = (SIZE_W'(offset) + s1_size_reg) > WORD_BYTES;
    assign block0  = {s1_addr_reg[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
    assign block1  = {s1_addr_reg[ADDR_W-1:OFF_W] + (ADDR_W-OFF_W)'(1), {OFF_W{1'b0}}};

    always_comb begin
        push_entry.addr = s1_addr_reg;
        push_entry.size = s1_size_reg;
        push_entry.data = s1_data_reg;
        priority if (in_mmio(s1_addr_reg) || !crosses) begin
            push_entry.cls = CLS_DIRECT;
        end else if (in_mmio(block0) || in_mmio(block1)) begin
            push_entry.cls = CLS_ERROR;
        end else begin
            push_entry.cls = CLS_SPLIT;
        end
    end

    assign push = s1_valid_reg;

endmodule

// ===== rtl/mss_queue.sv =====
module mss_queue
    import mss_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    input  logic   pop,
    output logic   empty,
    output entry_t head
);

    entry_t                 mem_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;

    // Store incoming word; space is guaranteed by the credit count
    always_ff @(posedge clk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    // Advance pointers and fill level
    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + QUEUE_CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + QUEUE_PTR_W'(1);
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + QUEUE_PTR_W'(1);
            end
            count_reg <= count_next;
        end
    end

    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

endmodule

// ===== rtl/mss_back.sv =====
module mss_back
    import mss_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    empty,
    input  entry_t  head,
    output logic    pop,
    output logic    result_valid,
    output result_t result
);

    back_state_t       state_reg;
    back_state_t       state_next;
    logic              valid_reg;
    logic              valid_next;
    result_t           result_reg;
    result_t           result_next;

    logic [OFF_W-1:0]  offset;
    logic [SIZE_W-1:0] first_bytes;
    logic [SIZE_W-1:0] second_bytes;
    logic [ADDR_W-1:0] block0;
    logic [ADDR_W-1:0] block1;
    result_t           direct_word;
    result_t           error_word;
    result_t           first_word;
    result_t           second_word;

    // Build the candidate words from the queue head
    assign offset       = head.addr[OFF_W-1:0];
    assign first_bytes  = WORD_BYTES - SIZE_W'(offset);
    assign second_bytes = head.size - first_bytes;
    assign block0       = {head.addr[ADDR_W-1:OFF_W], {OFF_W{1'b0}}};
    assign block1       = {head.addr[ADDR_W-1:OFF_W] + (ADDR_W-OFF_W)'(1), {OFF_W{1'b0}}};

    always_comb begin
        direct_word.kind   = PART_DIRECT;
        direct_word.addr   = head.addr;
        direct_word.offset = offset;
        direct_word.bytes  = head.size;
        direct_word.data   = head.data;
        direct_word.last   = 1'b1;

        error_word.kind    = PART_ERROR;
        error_word.addr    = head.addr;
        error_word.offset  = '0;
        error_word.bytes   = '0;
        error_word.data    = '0;
        error_word.last    = 1'b1;

        first_word.kind    = PART_BLOCK;
        first_word.addr    = block0;
        first_word.offset  = offset;
        first_word.bytes   = first_bytes;
        first_word.data    = head.data & byte_mask(first_bytes);
        first_word.last    = 1'b0;

        second_word.kind   = PART_BLOCK;
        second_word.addr   = block1;
        second_word.offset = '0;
        second_word.bytes  = second_bytes;
        second_word.data   = head.data >> {first_bytes[OFF_W-1:0], 3'b000};
        second_word.last   = 1'b1;
    end

    // Next state: a split store holds the head on into BACK_SECOND
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BACK_FIRST: begin
                if (!empty && (head.cls == CLS_SPLIT)) begin
                    state_next = BACK_SECOND;
                end
            end
            BACK_SECOND: begin
                state_next = BACK_FIRST;
            end
            default: begin
                state_next = BACK_FIRST;
            end
        endcase
    end

    // Outputs: select the word to issue and drop the head on its last word
    always_comb begin
        pop         = 1'b0;
        valid_next  = 1'b0;
        result_next = direct_word;
        unique case (state_reg)
            BACK_FIRST: begin
                if (!empty) begin
                    valid_next = 1'b1;
                    unique case (head.cls)
                        CLS_DIRECT: begin
                            result_next = direct_word;
                            pop         = 1'b1;
                        end
                        CLS_ERROR: begin
                            result_next = error_word;
                            pop         = 1'b1;
                        end
                        CLS_SPLIT: begin
                            result_next = first_word;
                        end
                        default: begin
                            result_next = error_word;
                            pop         = 1'b1;
                        end
                    endcase
                end
            end
            BACK_SECOND: begin
                valid_next  = 1'b1;
                result_next = second_word;
                pop         = 1'b1;
            end
            default: begin
                valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            state_reg <= BACK_FIRST;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk) begin
        if (valid_next) begin
            result_reg <= result_next;
        end
    end

    assign result_valid = valid_reg;
    assign result       = result_reg;

endmodule

// ===== rtl/misaligned_store_splitter_unit.sv =====
// Takes one store per cycle on start while busy is low and issues its result words, one
// word per cycle, each marked by result_valid for one cycle. A store that stays inside
// one 8-byte word, or starts in an MMIO range, gives one direct word; a word-crossing
// store gives two block words on consecutive cycles, or a single error word if either
// block is MMIO. Inactive vector elements and zero-size stores give no word and leave
// no trace. The two-stage classifier feeds the issue side through a four-entry queue,
// so a steady stream of unsplit stores sustains one store per cycle; a split store holds
// the queue head while its second word issues, and busy rises when four stores that give
// words are not yet fully issued. The receiver cannot stall, so every word must be taken
// the cycle it appears. Write the range registers only while idle.
module misaligned_store_splitter_unit
    import mss_pkg::*;
#(
    parameter int NUM_MMIO_RANGES = DEF_MMIO_RANGES
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  logic                 kind,
    input  logic [ADDR_W-1:0]    address,
    input  logic [INDEX_W-1:0]   element_index,
    input  logic [SIZE_W-1:0]    byte_count,
    input  logic [DATA_W-1:0]    store_data,
    input  logic                 active,
    input  logic                 cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DATA_W-1:0]    cfg_data,
    output logic                 result_valid,
    output logic [KIND_W-1:0]    part_kind,
    output logic [ADDR_W-1:0]    write_address,
    output logic [OFF_W-1:0]     byte_offset,
    output logic [SIZE_W-1:0]    part_bytes,
    output logic [DATA_W-1:0]    part_data,
    output logic                 last
);

    logic                   accept;
    logic                   load;
    logic                   push;
    logic                   pop;
    logic                   empty;
    entry_t                 push_entry;
    entry_t                 head;
    result_t                result;
    logic [QUEUE_CNT_W-1:0] credit_reg;
    logic [QUEUE_CNT_W-1:0] credit_next;

    assign accept = start && !busy;
    assign busy   = (credit_reg == QUEUE_CNT_W'(QUEUE_DEPTH));

    // Count stores taken but not yet fully issued
    always_comb begin
        credit_next = credit_reg;
        if (load && !pop) begin
            credit_next = credit_reg + QUEUE_CNT_W'(1);
        end else if (pop && !load) begin
            credit_next = credit_reg - QUEUE_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            credit_reg <= '0;
        end else begin
            credit_reg <= credit_next;
        end
    end

    mss_front #(
        .NUM_MMIO_RANGES(NUM_MMIO_RANGES)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .kind         (kind),
        .address      (address),
        .element_index(element_index),
        .byte_count   (byte_count),
        .store_data   (store_data),
        .active       (active),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .load         (load),
        .push         (push),
        .push_entry   (push_entry)
    );

    mss_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_entry(push_entry),
        .pop       (pop),
        .empty     (empty),
        .head      (head)
    );

    mss_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .result_valid(result_valid),
        .result      (result)
    );

    // Drive the result ports
    assign part_kind     = result.kind;
    assign write_address = result.addr;
    assign byte_offset   = result.offset;
    assign part_bytes    = result.bytes;
    assign part_data     = result.data;
    assign last          = result.last;

endmodule

// ===== rtl/mss_checker.sv =====
module mss_checker
    import mss_pkg::*;
(
    input logic              clk,
    input logic              rst_n,
    input logic              result_valid,
    input logic [KIND_W-1:0] part_kind,
    input logic [ADDR_W-1:0] write_address,
    input logic [OFF_W-1:0]  byte_offset,
    input logic [SIZE_W-1:0] part_bytes,
    input logic [DATA_W-1:0] part_data,
    input logic              last
);

    // The first block word of a split is followed at once by the closing block word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |=> result_valid && last && (part_kind == PART_BLOCK))
        else $error("split store not closed by second block word");

    // A non-final word is always the first block, which runs to the end of its word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !last |-> (part_kind == PART_BLOCK)
            && (write_address[OFF_W-1:0] == '0)
            && ((SIZE_W'(byte_offset) + part_bytes) == WORD_BYTES))
        else $error("first block word malformed");

    // Error words carry no bytes and end their store
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (part_kind == PART_ERROR) |-> last && (part_bytes == '0)
            && (part_data == '0) && (byte_offset == '0))
        else $error("error word malformed");

    // Direct words are single, keep the low address bits and never exceed a word
    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (part_kind == PART_DIRECT) |-> last
            && (byte_offset == write_address[OFF_W-1:0])
            && (part_bytes != '0) && (part_bytes <= WORD_BYTES))
        else $error("direct word malformed");

endmodule

bind misaligned_store_splitter_unit mss_checker u_mss_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result_valid),
    .part_kind    (part_kind),
    .write_address(write_address),
    .byte_offset  (byte_offset),
    .part_bytes   (part_bytes),
    .part_data    (part_data),
    .last         (last)
);
